/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, switched off while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("assertion failed");

// Next-cycle implication that is checked during reset as well.
`define ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/lgc_pkg.sv */
// ----------------------------------------------------------------------------
// lgc_pkg
// Types and constants of the lightmap gain and hue-preserving clamp block.
// ----------------------------------------------------------------------------
`default_nettype none

package lgc_pkg;

  localparam int CHAN_W             = 8;
  localparam int GAIN_W             = 16;
  localparam int PROD_W             = CHAN_W + GAIN_W;
  localparam int DIVIDEND_W         = 2 * CHAN_W;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = CHAN_W / DIV_BITS_PER_STAGE;
  // Product stage, compare stage, divider stages, output register.
  localparam int LATENCY            = DIV_STAGES + 3;

  localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'hFF;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd640;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              clamped;
  } result_t;

  // Pipeline payload through the divider. Index 2 is red, 1 green, 0 blue.
  // work holds {partial remainder, remaining dividend bits, quotient bits}.
  typedef struct packed {
    logic [2:0][DIVIDEND_W-1:0] work;
    logic [CHAN_W-1:0]          divisor;
    logic [2:0][CHAN_W-1:0]     plain;
    logic                       over;
  } pipe_t;

endpackage

`default_nettype wire

/* sv/lgc_front.sv */
// ----------------------------------------------------------------------------
// lgc_front
// Gain multiply, saturation detect, channel maximum and divider setup.
// ----------------------------------------------------------------------------
`default_nettype none

module lgc_front #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  lgc_pkg::pixel_t                   pixel,
  input  logic [lgc_pkg::GAIN_W-1:0]        gain,
  output logic                              out_valid,
  output lgc_pkg::pipe_t                    out_data
);

  localparam logic [lgc_pkg::PROD_W-1:0] LIMIT =
    {16'd0, lgc_pkg::CHAN_MAX} << GAIN_FRAC_BITS;

  logic                                  a_valid;
  logic [2:0][lgc_pkg::CHAN_W-1:0]       a_chan;
  logic [2:0][lgc_pkg::PROD_W-1:0]       a_prod;
  logic [2:0][lgc_pkg::CHAN_W-1:0]       chan_in;
  logic [2:0][lgc_pkg::PROD_W-1:0]       a_prod_next;
  logic [lgc_pkg::CHAN_W-1:0]            max_rg;
  lgc_pkg::pipe_t                        out_data_next;

  assign chan_in = {pixel.red_in, pixel.green_in, pixel.blue_in};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      a_prod_next[c] = {16'd0, chan_in[c]} * {8'd0, gain};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_chan <= chan_in;
    a_prod <= a_prod_next;
  end

  // The dividend chan * 255 is formed as (chan << 8) - chan.
  always_comb begin
    max_rg = (a_chan[1] > a_chan[2]) ? a_chan[1] : a_chan[2];
    out_data_next.divisor = (a_chan[0] > max_rg) ? a_chan[0] : max_rg;
    out_data_next.over = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if (a_prod[c] > LIMIT) begin
        out_data_next.over = 1'b1;
      end
      out_data_next.plain[c] = a_prod[c][GAIN_FRAC_BITS +: lgc_pkg::CHAN_W];
      out_data_next.work[c]  = {a_chan[c], 8'd0} - {8'd0, a_chan[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
    out_data <= out_data_next;
  end

endmodule

`default_nettype wire

/* sv/lgc_div_stage.sv */
// ----------------------------------------------------------------------------
// lgc_div_stage
// One registered slice of the restoring divider, all three channels at once.
// ----------------------------------------------------------------------------
`default_nettype none

module lgc_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  lgc_pkg::pipe_t in_data,
  output logic           out_valid,
  output lgc_pkg::pipe_t out_data
);

  lgc_pkg::pipe_t            out_data_next;
  logic [lgc_pkg::CHAN_W:0]  trial;
  logic [lgc_pkg::CHAN_W:0]  remain;
  logic                      qbit;

  // Each step shifts one dividend bit into the remainder and one quotient
  // bit into the bottom of the work word.
  always_comb begin
    out_data_next = in_data;
    trial  = '0;
    remain = '0;
    qbit   = 1'b0;
    for (int s = 0; s < lgc_pkg::DIV_BITS_PER_STAGE; s++) begin
      for (int c = 0; c < 3; c++) begin
        trial = out_data_next.work[c][lgc_pkg::DIVIDEND_W-1:lgc_pkg::CHAN_W-1];
        if (trial >= {1'b0, in_data.divisor}) begin
          remain = trial - {1'b0, in_data.divisor};
          qbit   = 1'b1;
        end else begin
          remain = trial;
          qbit   = 1'b0;
        end
        out_data_next.work[c] = {remain[lgc_pkg::CHAN_W-1:0],
                                 out_data_next.work[c][lgc_pkg::CHAN_W-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_data <= out_data_next;
  end

endmodule

`default_nettype wire

/* sv/lightmap_gamma_hue_preserving_clamp.sv */
// ----------------------------------------------------------------------------
// lightmap_gamma_hue_preserving_clamp
// RGB gain with hue-preserving saturation, fully pipelined.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock edge at which start is high and busy is
// low; busy is high only while reset is held, so one pixel per cycle can be
// fed without pause. Each pixel's result appears on result for exactly one
// cycle, flagged by done, after the beat has passed every pipeline stage. The
// receiver cannot stall the block and must take every result as it comes.
// The gain register is written through cfg_we and cfg_wdata and should only
// change while no pixel is in flight; it resets to 2.5 at eight fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lightmap_gamma_hue_preserving_clamp #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  lgc_pkg::pixel_t            pixel,
  input  logic                       cfg_we,
  input  logic [lgc_pkg::GAIN_W-1:0] cfg_wdata,
  output logic                       done,
  output lgc_pkg::result_t           result
);

  // Pipeline layout, one register per step:
  //   1. the three 8x16 gain products,
  //   2. the saturation compare, the channel maximum and the dividend
  //      chan * 255 for each channel,
  //   3..6. the restoring divider, two quotient bits per stage,
  //   7. the output register, which picks the truncated product or the
  //      scaled-down quotient.
  // Valid bits follow the data and nothing ever holds, so the rate is one
  // pixel per clock.

  logic [lgc_pkg::GAIN_W-1:0] gain;
  logic                       accept;

  logic                       stage_valid [lgc_pkg::DIV_STAGES+1];
  lgc_pkg::pipe_t             stage_data  [lgc_pkg::DIV_STAGES+1];

  lgc_pkg::result_t           result_next;

  assign busy   = rst;
  assign accept = start && !busy;

  // Gain register. The user must make writes only while the pipeline is empty; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= lgc_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      gain <= cfg_wdata;
    end
  end

  lgc_front #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .pixel     (pixel),
    .gain      (gain),
    .out_valid (stage_valid[0]),
    .out_data  (stage_data[0])
  );

  // The quotient never exceeds 255 because every channel is at most the
  // maximum, so only the low dividend byte needs quotient steps.
  for (genvar g = 0; g < lgc_pkg::DIV_STAGES; g++) begin : g_div
    lgc_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[g]),
      .in_data   (stage_data[g]),
      .out_valid (stage_valid[g+1]),
      .out_data  (stage_data[g+1])
    );
  end

  // When no product is over the limit the truncated product is used as is.
  // A product of exactly 255.0 counts as not over. Otherwise the quotient
  // bits from the divider give chan * 255 / max, with the largest at 255.
  always_comb begin
    if (stage_data[lgc_pkg::DIV_STAGES].over) begin
      result_next.red_out   = stage_data[lgc_pkg::DIV_STAGES].work[2][lgc_pkg::CHAN_W-1:0];
      result_next.green_out = stage_data[lgc_pkg::DIV_STAGES].work[1][lgc_pkg::CHAN_W-1:0];
      result_next.blue_out  = stage_data[lgc_pkg::DIV_STAGES].work[0][lgc_pkg::CHAN_W-1:0];
      result_next.clamped   = 1'b1;
    end else begin
      result_next.red_out   = stage_data[lgc_pkg::DIV_STAGES].plain[2];
      result_next.green_out = stage_data[lgc_pkg::DIV_STAGES].plain[1];
      result_next.blue_out  = stage_data[lgc_pkg::DIV_STAGES].plain[0];
      result_next.clamped   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid[lgc_pkg::DIV_STAGES];
    end
    result <= result_next;
  end

endmodule

`default_nettype wire

/* sv/lgc_checker.sv */
// ----------------------------------------------------------------------------
// lgc_checker
// Port-level timing and result checks for the lightmap gain block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lgc_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input lgc_pkg::result_t result
);

  localparam int LAT = lgc_pkg::LATENCY;

  logic accept;
  logic top_at_max;

  assign accept     = start && !busy;
  assign top_at_max = (result.red_out == lgc_pkg::CHAN_MAX) ||
                      (result.green_out == lgc_pkg::CHAN_MAX) ||
                      (result.blue_out == lgc_pkg::CHAN_MAX);

  // Every accepted beat yields one result after the fixed latency.
  `ASSERT_IMPL(a_result_follows, clk, rst, accept, ##LAT done)
  // No result shows up without a beat taken the same latency earlier.
  `ASSERT_IMPL(a_no_phantom, clk, rst, done, $past(accept, LAT))
  // A clamped pixel always has its largest channel at full scale.
  `ASSERT_IMPL(a_clamp_full, clk, rst, done && result.clamped, top_at_max)
  // Reset flushes the pipeline.
  `ASSERT_NEXT(a_reset_flush, clk, rst, !done)

endmodule

bind lightmap_gamma_hue_preserving_clamp lgc_checker u_lgc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB gain block with hue-preserving clamp.
// Pixels are sent with random gaps. Every result is compared field by field
// with a prediction made in the bench when the pixel beat is taken. The gain
// register is swept through its extremes and a set of random settings.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CHAN_W      = lgc_pkg::CHAN_W;
  localparam int GAIN_W      = lgc_pkg::GAIN_W;
  localparam int PROD_W      = lgc_pkg::PROD_W;
  localparam int DIVIDEND_W  = lgc_pkg::DIVIDEND_W;

  localparam int FRAC_BITS   = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int GAP_MAX     = 10;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  lgc_pkg::pixel_t  pixel;
  logic    cfg_we;
  logic [GAIN_W-1:0] cfg_wdata;
  logic    done;
  lgc_pkg::result_t result;

  lightmap_gamma_hue_preserving_clamp #(
    .GAIN_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .pixel    (pixel),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .done     (done),
    .result   (result)
  );

  // Results predicted for accepted pixels, oldest first.
  lgc_pkg::result_t pending_results[$];

  // Gain as the block should hold it, tracked at the clock edge.
  logic [GAIN_W-1:0] gain_model;
  // Gain as the stimulus side last wrote it, used only to shape pixels.
  logic [GAIN_W-1:0] gain_written;

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned clamped_seen;
  int unsigned gain_writes;
  bit          burst_mode;

  lgc_pkg::result_t expected_beat;

  always #1 clk = ~clk;

  // Run limit. A hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Prediction of one result. Each channel is multiplied by the gain; if any
  // product is above 255.0 in fixed point, all channels are scaled together
  // so that the brightest lands on 255, otherwise the products are truncated.
  function automatic lgc_pkg::result_t predict_pixel(lgc_pkg::pixel_t p,
                                                     logic [GAIN_W-1:0] g);
    logic [CHAN_W-1:0] chan[3];
    logic [CHAN_W-1:0] outc[3];
    logic [PROD_W-1:0] prod[3];
    logic [PROD_W-1:0] limit;
    logic [CHAN_W-1:0] peak;
    logic [DIVIDEND_W-1:0] scaled;
    logic              over;
    lgc_pkg::result_t  r;
    chan[0] = p.red_in;
    chan[1] = p.green_in;
    chan[2] = p.blue_in;
    limit   = PROD_W'(lgc_pkg::CHAN_MAX) << FRAC_BITS;
    over    = 1'b0;
    peak    = '0;
    for (int i = 0; i < 3; i++) begin
      prod[i] = PROD_W'(chan[i]) * PROD_W'(g);
      if (prod[i] > limit) over = 1'b1;
      if (chan[i] > peak) peak = chan[i];
    end
    for (int i = 0; i < 3; i++) begin
      if (over) begin
        // The gain cancels out once the clamp applies; the peak is nonzero
        // here since some product was above the limit.
        scaled  = (peak != 0) ? (DIVIDEND_W'(chan[i]) * DIVIDEND_W'(lgc_pkg::CHAN_MAX))
                                / DIVIDEND_W'(peak) : '0;
        outc[i] = scaled[CHAN_W-1:0];
      end else begin
        outc[i] = prod[i][FRAC_BITS +: CHAN_W];
      end
    end
    r.red_out   = outc[0];
    r.green_out = outc[1];
    r.blue_out  = outc[2];
    r.clamped   = over;
    return r;
  endfunction

  task automatic check_field(string name, logic [CHAN_W-1:0] want,
                             logic [CHAN_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // One process both checks results and records accepted beats, so the
  // order of the queue operations within an edge is fixed. A result can
  // never belong to a beat taken at the same edge, hence check first.
  always @(posedge clk) begin
    if (rst) begin
      gain_model = lgc_pkg::GAIN_RESET;
    end else begin
      if (done) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
        end else begin
          expected_beat = pending_results.pop_front();
          check_field("red_out", expected_beat.red_out, result.red_out);
          check_field("green_out", expected_beat.green_out, result.green_out);
          check_field("blue_out", expected_beat.blue_out, result.blue_out);
          check_field("clamped", CHAN_W'(expected_beat.clamped), CHAN_W'(result.clamped));
          if (result.clamped === 1'b1) clamped_seen++;
        end
      end
      if (start && !busy) begin
        pending_results = {pending_results, predict_pixel(pixel, gain_model)};
      end
      if (cfg_we) gain_model = cfg_wdata;
    end
  end

  // Sender gap per beat: none while in a burst, otherwise 0 to GAP_MAX.
  function automatic int unsigned draw_gap();
    return burst_mode ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // Sends one pixel beat. Called at a falling edge; returns at the falling
  // edge after the beat was taken, with start still high so that a
  // back-to-back beat keeps it high without a glitch.
  task automatic send_pixel(lgc_pkg::pixel_t p, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted result has come back.
  // Each beat yields a result, so an empty queue means an idle pipeline;
  // the extra cycles are only a margin.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (lgc_pkg::LATENCY) @(negedge clk);
  endtask

  task automatic write_gain(logic [GAIN_W-1:0] g);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_we    <= 1'b0;
    gain_written = g;
    gain_writes++;
  endtask

  // Random pixel shaped by the current gain. A good share of the beats sit
  // around the channel value where the product crosses 255.0, so both the
  // plain and the clamped path are hit at every gain above unity.
  function automatic lgc_pkg::pixel_t random_pixel(logic [GAIN_W-1:0] g);
    int unsigned mode;
    int unsigned knee;
    int          val;
    logic [CHAN_W-1:0] chan[3];
    lgc_pkg::pixel_t p;
    knee = (g == 0) ? 255 : ((255 << FRAC_BITS) / g);
    if (knee > 255) knee = 255;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0: begin
          chan[i] = CHAN_W'($urandom_range(0, 255));
        end
        1: begin
          chan[i] = CHAN_W'($urandom_range(0, knee));
        end
        2: begin
          val = int'(knee) + $urandom_range(0, 4) - 2;
          if (val < 0) val = 0;
          if (val > 255) val = 255;
          chan[i] = CHAN_W'(val);
        end
        default: begin
          chan[i] = (i == 0) ? CHAN_W'($urandom_range(0, 255)) : chan[0];
        end
      endcase
    end
    p.red_in   = chan[0];
    p.green_in = chan[1];
    p.blue_in  = chan[2];
    return p;
  endfunction

  // Pixels at the reset gain of 2.5, before any register write. Channel 102
  // gives a product of exactly 255.0, which must not clamp.
  task automatic test_reset_gain();
    send_pixel('{8'd0, 8'd0, 8'd0}, 0);
    send_pixel('{8'd255, 8'd255, 8'd255}, 0);
    send_pixel('{8'd102, 8'd102, 8'd102}, 1);
    send_pixel('{8'd103, 8'd50, 8'd0}, 0);
    send_pixel('{8'd255, 8'd0, 8'd1}, 2);
    send_pixel('{8'd1, 8'd2, 8'd3}, 0);
    send_pixel('{8'd170, 8'd85, 8'd51}, 0);
  endtask

  // Directed pixels at the register extremes and around unity gain.
  task automatic test_gain_extremes();
    // Zero gain: everything black, nothing clamped.
    write_gain(16'd0);
    send_pixel('{8'd255, 8'd255, 8'd255}, 0);
    send_pixel('{8'd128, 8'd64, 8'd1}, 0);
    // Largest gain: any nonzero channel clamps.
    write_gain(16'hFFFF);
    send_pixel('{8'd1, 8'd0, 8'd0}, 0);
    send_pixel('{8'd0, 8'd0, 8'd0}, 0);
    send_pixel('{8'd0, 8'd255, 8'd7}, 0);
    send_pixel('{8'd200, 8'd100, 8'd3}, 0);
    // Unity gain: 255 lands exactly on the limit and passes through.
    write_gain(16'd256);
    send_pixel('{8'd255, 8'd254, 8'd0}, 0);
    send_pixel('{8'd85, 8'd170, 8'd255}, 0);
    // Just above unity: 255 clamps, 254 does not.
    write_gain(16'd257);
    send_pixel('{8'd255, 8'd128, 8'd1}, 0);
    send_pixel('{8'd254, 8'd254, 8'd254}, 0);
    // Smallest nonzero gain truncates everything to zero.
    write_gain(16'd1);
    send_pixel('{8'd255, 8'd255, 8'd255}, 0);
    drain_results();
  endtask

  // Random pixels over a sweep of gain settings.
  task automatic test_random_gains();
    logic [GAIN_W-1:0] sweep[10];
    sweep = '{16'd1, 16'd128, 16'd256, 16'd640, 16'd1000, 16'hFFFF,
              16'd0, 16'd0, 16'd0, 16'd0};
    for (int k = 6; k < 10; k++) sweep[k] = GAIN_W'($urandom_range(0, 16'hFFFF));
    foreach (sweep[k]) begin
      write_gain(sweep[k]);
      for (int n = 0; n < 65; n++) begin
        if (n % 16 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        send_pixel(random_pixel(gain_written), draw_gap());
      end
    end
    burst_mode = 1'b0;
    drain_results();
  endtask

  // The sender now and then holds off until the pipeline has fully emptied,
  // then resumes without touching the register.
  task automatic test_pause_until_empty();
    write_gain(GAIN_W'($urandom_range(300, 3000)));
    for (int n = 0; n < 80; n++) begin
      if ($urandom_range(0, 9) == 0) drain_results();
      send_pixel(random_pixel(gain_written), draw_gap());
    end
    drain_results();
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    pixel        = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    gain_written = lgc_pkg::GAIN_RESET;
    burst_mode   = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    pixels_sent  = 0;
    results_seen = 0;
    clamped_seen = 0;
    gain_writes  = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_gain();
    test_gain_extremes();
    test_random_gains();
    test_pause_until_empty();

    // All beats are in; let the last results arrive and then watch a little
    // longer for anything stray.
    drain_results();
    repeat (2 * lgc_pkg::LATENCY) @(negedge clk);

    $display("Sent %0d pixels over %0d gain settings; %0d results checked, %0d clamped.",
             pixels_sent, gain_writes + 1, results_seen, clamped_seen);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/lgc_pkg.sv
sv/lgc_front.sv
sv/lgc_div_stage.sv
sv/lightmap_gamma_hue_preserving_clamp.sv
sv/lgc_checker.sv
bench/testbench.sv
